@@ hdl/qpd_pkg.sv @@
// Package for the quoted-printable decoder.
// Holds the character codes, the escape phase type, the result word types and hex helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package qpd_pkg;

    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_EQ    = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [1:0]                cnt;
    } t_dec_out;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c - 8'h30;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c - 8'h37;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/quoted_printable_decoder_top.sv @@
// Top level of the quoted-printable decoder: input register, mode register,
// escape decoder and result buffer. Depends on qpd_pkg, qpd_decode and qpd_outbuf.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] = in_byte, tlast = word_end
//   m_axis    out        tdata[7:0] = out_byte, tuser = {run_last, byte_valid}, tlast = text_end
//   cfg       in         i_cfg_wr_data = decode_mode, written when i_cfg_wr_en is high
//
// An accepted word waits in the input register until the result buffer is free, is then
// decoded, and its first result appears on m_axis the cycle after.
// While m_axis_tready is high, the output moves one result per cycle, an item with k results
// holds it until all k have left, and items giving one result or none flow at one per cycle.
// A new word is taken while results of the previous one still wait.
// Reset is synchronous and active low and returns the decoder to idle with mode 0.
`timescale 1ns / 1ps
`default_nettype none

module quoted_printable_decoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      m_axis_tuser,   // [0] byte_valid, [1] run_last
    output logic            m_axis_tlast
);
    import qpd_pkg::*;

    logic       r_mode;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       w_load;
    logic       w_can_load;
    logic       w_pop;
    logic       w_accept;
    t_dec_out   w_dec;
    t_result    w_word;

    assign w_load        = r_in_valid && w_can_load;
    assign s_axis_tready = !r_in_valid || w_can_load;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    qpd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_load),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_mode  (r_mode),
        .o_out   (w_dec)
    );

    qpd_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_data     (w_dec),
        .i_pop      (w_pop),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .o_word     (w_word)
    );

    assign m_axis_tdata = w_word.out_byte;
    assign m_axis_tuser = {w_word.run_last, w_word.byte_valid};
    assign m_axis_tlast = w_word.text_end;

endmodule

`default_nettype wire

@@ hdl/qpd_decode.sv @@
// Escape decoder: holds the escape phase and the held digit, and turns one
// registered input word into up to three result words. Depends on qpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpd_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire logic            i_mode,
    output qpd_pkg::t_dec_out    o_out
);
    import qpd_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;
    t_phase     w_mid_phase;
    logic [7:0] w_mid_held;
    logic       w_hex;
    logic       w_plain;
    logic [7:0] w_plain_byte;

    assign w_hex        = is_hex(i_byte);
    assign w_plain_byte = (i_mode && (i_byte == CH_UNDERSCORE)) ? CH_SPACE : i_byte;

    always_comb begin
        w_mid_held = r_held;
        w_plain    = 1'b0;
        case (r_phase)
            PH_EQ: begin
                if (!i_mode && (i_byte == CH_NEWLINE)) begin
                    w_mid_phase = PH_IDLE;
                end else if (w_hex) begin
                    w_mid_phase = PH_DIGIT;
                    w_mid_held  = i_byte;
                end else begin
                    w_mid_phase = (i_byte == CH_EQUALS) ? PH_EQ : PH_IDLE;
                    w_plain     = 1'b1;
                end
            end
            PH_DIGIT: begin
                w_mid_held = 8'h00;
                if (w_hex) begin
                    w_mid_phase = PH_IDLE;
                end else begin
                    w_mid_phase = (i_byte == CH_EQUALS) ? PH_EQ : PH_IDLE;
                    w_plain     = 1'b1;
                end
            end
            default: begin
                w_mid_phase = (i_byte == CH_EQUALS) ? PH_EQ : PH_IDLE;
                w_plain     = 1'b1;
            end
        endcase
        n_phase = i_last ? PH_IDLE : w_mid_phase;
        n_held  = i_last ? 8'h00 : w_mid_held;
    end

    always_comb begin
        logic [7:0] v_buf [MAX_RESULTS];
        logic [1:0] v_n;
        logic [1:0] v_top;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            v_buf[k] = 8'h00;
        end
        v_n = 2'd0;
        case (r_phase)
            PH_EQ: begin
                if (w_plain) begin
                    v_buf[v_n] = CH_EQUALS;
                    v_n        = v_n + 2'd1;
                end
            end
            PH_DIGIT: begin
                if (w_hex) begin
                    v_buf[v_n] = {hex_value(r_held), hex_value(i_byte)};
                    v_n        = v_n + 2'd1;
                end else begin
                    v_buf[v_n] = CH_EQUALS;
                    v_n        = v_n + 2'd1;
                    v_buf[v_n] = r_held;
                    v_n        = v_n + 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (w_plain && (i_byte != CH_EQUALS)) begin
            v_buf[v_n] = w_plain_byte;
            v_n        = v_n + 2'd1;
        end
        if (i_last) begin
            if (w_mid_phase == PH_EQ) begin
                v_buf[v_n] = CH_EQUALS;
                v_n        = v_n + 2'd1;
            end else if (w_mid_phase == PH_DIGIT) begin
                v_buf[v_n] = CH_EQUALS;
                v_n        = v_n + 2'd1;
                v_buf[v_n] = w_mid_held;
                v_n        = v_n + 2'd1;
            end
        end
        v_top = v_n - 2'd1;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            o_out.res[k].out_byte   = v_buf[k];
            o_out.res[k].byte_valid = (2'(k) < v_n);
            o_out.res[k].run_last   = (v_n != 2'd0) && (2'(k) == v_top);
            o_out.res[k].text_end   = i_last && (v_n != 2'd0) && (2'(k) == v_top);
        end
        o_out.cnt = v_n;
        if (i_last && (v_n == 2'd0)) begin
            o_out.res[0].out_byte   = 8'h00;
            o_out.res[0].byte_valid = 1'b0;
            o_out.res[0].run_last   = 1'b1;
            o_out.res[0].text_end   = 1'b1;
            o_out.cnt               = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

@@ hdl/qpd_outbuf.sv @@
// Result buffer: takes the up to three result words of one item at once and
// hands them out in order, one per cycle while popped. Depends on qpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpd_outbuf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire qpd_pkg::t_dec_out  i_data,
    input  wire logic               i_pop,
    output logic                    o_can_load,
    output logic                    o_valid,
    output qpd_pkg::t_result        o_word
);
    import qpd_pkg::*;

    t_result [MAX_RESULTS-1:0] r_slot;
    logic [1:0]                r_cnt;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_word     = r_slot[0];
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_data.cnt;
        end else if (i_pop && (r_cnt != 2'd0)) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_data.res;
        end else if (i_pop) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

    a_run_last_is_final_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.run_last) |-> (r_cnt == 2'd1))
        else $error("run_last shown with further words of the run still buffered");

    a_stall_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt != 2'd0) && !i_pop) |=> (r_cnt == $past(r_cnt)))
        else $error("buffered word count changed while the output stalled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && (r_cnt > 2'd1)) |-> 1'b0)
        else $error("new item loaded over undelivered words");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && (r_cnt == 2'd1) && !i_load) |=> (r_cnt == 2'd0))
        else $error("buffer not empty after its final word left");

endmodule

`default_nettype wire
